FILE: rtl/core/rldm_pkg.sv
// Shared types, constants and saturation helpers for the radial lens distortion map.
package rldm_pkg;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FOCAL_LENGTH  = 3'd0;
    localparam t_cfg_idx CFG_INVERSE_FOCAL = 3'd1;
    localparam t_cfg_idx CFG_CENTER_X      = 3'd2;
    localparam t_cfg_idx CFG_CENTER_Y      = 3'd3;
    localparam t_cfg_idx CFG_COEFF_K1      = 3'd4;
    localparam t_cfg_idx CFG_COEFF_K2      = 3'd5;
    localparam t_cfg_idx CFG_COEFF_K3      = 3'd6;

    // Register reset values.
    localparam logic [31:0] RST_FOCAL_LENGTH  = 32'd65536000;
    localparam logic [31:0] RST_INVERSE_FOCAL = 32'd4294967;
    localparam logic [15:0] RST_CENTER_X      = 16'd10240;
    localparam logic [15:0] RST_CENTER_Y      = 16'd7680;

    // Fraction bits of the normalized coordinate, powers and coefficients.
    localparam int NORM_FRAC = 28;

    // The constant one of the scale polynomial in Q3.28.
    localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic [63:0]        U32_MAX = 64'd4294967295;
    localparam logic signed [64:0] OUT_MIN = -65'sd524288;
    localparam logic signed [64:0] OUT_MAX = 65'sd524287;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat32;

    typedef struct packed {
        logic        ovf;
        logic [19:0] val;
    } t_sat20;

    // Clamp a signed value to the signed 32-bit range.
    function automatic t_sat32 sat_s32(input logic signed [63:0] v);
        t_sat32 res;
        res.ovf = 1'b0;
        res.val = v[31:0];
        if (v < S32_MIN) begin
            res.ovf = 1'b1;
            res.val = S32_MIN[31:0];
        end else if (v > S32_MAX) begin
            res.ovf = 1'b1;
            res.val = S32_MAX[31:0];
        end
        return res;
    endfunction

    // Clamp an unsigned value to the unsigned 32-bit range.
    function automatic t_sat32 sat_u32(input logic [63:0] v);
        t_sat32 res;
        res.ovf = 1'b0;
        res.val = v[31:0];
        if (v > U32_MAX) begin
            res.ovf = 1'b1;
            res.val = U32_MAX[31:0];
        end
        return res;
    endfunction

    // Clamp an output coordinate to the signed 20-bit range.
    function automatic t_sat20 sat_s20(input logic signed [64:0] v);
        t_sat20 res;
        res.ovf = 1'b0;
        res.val = v[19:0];
        if (v < OUT_MIN) begin
            res.ovf = 1'b1;
            res.val = OUT_MIN[19:0];
        end else if (v > OUT_MAX) begin
            res.ovf = 1'b1;
            res.val = OUT_MAX[19:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/radial_lens_distortion_map.sv
// Radial lens distortion map: fifteen-stage pipeline from pixel to distorted coordinate.
//
// Maps one undistorted pixel coordinate to its distorted position under the Brown radial
// model with k1, k2 and k3. The block takes one coordinate pair per clock cycle while
// the output is not stalled, giving results in order. Every stage holds at most one
// 32 by 32 multiply or one add and clamp step, and each stage has its own valid bit and
// moves forward whenever the stage after it is empty or moving, so an output stall only
// blocks input once all fifteen stages are full. Configuration is read directly by the
// stages and is to be written only while the pipeline is empty.
module radial_lens_distortion_map #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [19:0] distorted_x, [39:20] distorted_y
    output logic [0:0]  o_m_tuser    // [0] saturated
);

    localparam int NSTG       = 15;
    localparam int NormShift  = COORD_FRAC_BITS + 4;
    localparam int BackShift  = 16 + rldm_pkg::NORM_FRAC - COORD_FRAC_BITS - 1;

    // Configuration registers.
    logic        [31:0] r_focal;
    logic        [31:0] r_inv;
    logic        [15:0] r_cx;
    logic        [15:0] r_cy;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_k2;
    logic signed [31:0] r_k3;

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_rdy;
    logic            r_flg [1:NSTG-1];
    logic [NSTG-1:1] n_ovf;

    // Normalized coordinates travel alongside the radial work up to the stage 10 scale multiply.
    logic signed [31:0] r_nx [1:9];
    logic signed [31:0] r_ny [1:9];

    // Stage registers.
    logic signed [49:0] r_s0_px, r_s0_py;
    logic signed [63:0] r_s2_sqx, r_s2_sqy;
    logic        [31:0] r_s3_r2;
    logic        [63:0] r_s4_r2sq;
    logic signed [64:0] r_s4_t1p;
    logic        [31:0] r_s4_r2;
    logic        [31:0] r_s5_r4;
    logic        [31:0] r_s5_r2;
    logic signed [36:0] r_s5_t1;
    logic        [63:0] r_s6_r4r2;
    logic signed [64:0] r_s6_t2p;
    logic signed [36:0] r_s6_t1;
    logic        [31:0] r_s7_r6;
    logic signed [37:0] r_s7_t12;
    logic signed [64:0] r_s8_t3p;
    logic signed [37:0] r_s8_t12;
    logic signed [31:0] r_s9_s;
    logic signed [63:0] r_s10_px, r_s10_py;
    logic signed [31:0] r_s11_dx, r_s11_dy;
    logic signed [64:0] r_s12_px, r_s12_py;
    logic signed [64:0] r_s13_hx, r_s13_hy;
    logic        [19:0] r_s14_x, r_s14_y;

    // Next values.
    logic signed [16:0] n_s0_dx, n_s0_dy;
    logic signed [49:0] n_s0_px, n_s0_py;
    logic signed [49:0] n_s1_shx, n_s1_shy;
    rldm_pkg::t_sat32   n_s1_nx, n_s1_ny;
    logic signed [63:0] n_s2_sqx, n_s2_sqy;
    logic        [63:0] n_s3_sum;
    rldm_pkg::t_sat32   n_s3_r2;
    logic        [63:0] n_s4_r2sq;
    logic signed [64:0] n_s4_t1p;
    rldm_pkg::t_sat32   n_s5_r4;
    logic signed [64:0] n_s5_t1f;
    logic        [63:0] n_s6_r4r2;
    logic signed [64:0] n_s6_t2p;
    rldm_pkg::t_sat32   n_s7_r6;
    logic signed [64:0] n_s7_t2f;
    logic signed [37:0] n_s7_t12;
    logic signed [64:0] n_s8_t3p;
    logic signed [64:0] n_s9_t3f;
    logic signed [63:0] n_s9_sum;
    rldm_pkg::t_sat32   n_s9_s;
    logic signed [63:0] n_s10_px, n_s10_py;
    rldm_pkg::t_sat32   n_s11_dx, n_s11_dy;
    logic signed [64:0] n_s12_px, n_s12_py;
    logic signed [64:0] n_s13_shx, n_s13_shy;
    logic signed [64:0] n_s13_hx, n_s13_hy;
    rldm_pkg::t_sat20   n_s14_x, n_s14_y;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= rldm_pkg::RST_FOCAL_LENGTH;
            r_inv   <= rldm_pkg::RST_INVERSE_FOCAL;
            r_cx    <= rldm_pkg::RST_CENTER_X;
            r_cy    <= rldm_pkg::RST_CENTER_Y;
            r_k1    <= '0;
            r_k2    <= '0;
            r_k3    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rldm_pkg::CFG_FOCAL_LENGTH:  r_focal <= i_cfg_data;
                rldm_pkg::CFG_INVERSE_FOCAL: r_inv   <= i_cfg_data;
                rldm_pkg::CFG_CENTER_X:      r_cx    <= i_cfg_data[15:0];
                rldm_pkg::CFG_CENTER_Y:      r_cy    <= i_cfg_data[15:0];
                rldm_pkg::CFG_COEFF_K1:      r_k1    <= i_cfg_data;
                rldm_pkg::CFG_COEFF_K2:      r_k2    <= i_cfg_data;
                rldm_pkg::CFG_COEFF_K3:      r_k3    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it is loading.
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_s_tready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Datapath arithmetic, one step per stage.
    always_comb begin
        n_ovf = '0;

        // Stage 0: offset from the principal point times the inverse focal.
        n_s0_dx = $signed({1'b0, i_s_tdata[15:0]}) - $signed({1'b0, r_cx});
        n_s0_dy = $signed({1'b0, i_s_tdata[31:16]}) - $signed({1'b0, r_cy});
        n_s0_px = n_s0_dx * $signed({1'b0, r_inv});
        n_s0_py = n_s0_dy * $signed({1'b0, r_inv});

        // Stage 1: scale to Q3.28 and clamp.
        n_s1_shx = r_s0_px >>> NormShift;
        n_s1_shy = r_s0_py >>> NormShift;
        n_s1_nx  = rldm_pkg::sat_s32({{14{n_s1_shx[49]}}, n_s1_shx});
        n_s1_ny  = rldm_pkg::sat_s32({{14{n_s1_shy[49]}}, n_s1_shy});
        n_ovf[1] = n_s1_nx.ovf || n_s1_ny.ovf;

        // Stage 2: squares.
        n_s2_sqx = r_nx[1] * r_nx[1];
        n_s2_sqy = r_ny[1] * r_ny[1];

        // Stage 3: squared radius.
        n_s3_sum = $unsigned(r_s2_sqx) + $unsigned(r_s2_sqy);
        n_s3_r2  = rldm_pkg::sat_u32(n_s3_sum >> rldm_pkg::NORM_FRAC);
        n_ovf[3] = n_s3_r2.ovf;

        // Stage 4: r2 squared and the k1 product.
        n_s4_r2sq = r_s3_r2 * r_s3_r2;
        n_s4_t1p  = r_k1 * $signed({1'b0, r_s3_r2});

        // Stage 5: fourth power and the k1 term.
        n_s5_r4  = rldm_pkg::sat_u32(r_s4_r2sq >> rldm_pkg::NORM_FRAC);
        n_s5_t1f = r_s4_t1p >>> rldm_pkg::NORM_FRAC;
        n_ovf[5] = n_s5_r4.ovf;

        // Stage 6: r4 times r2 and the k2 product.
        n_s6_r4r2 = r_s5_r4 * r_s5_r2;
        n_s6_t2p  = r_k2 * $signed({1'b0, r_s5_r4});

        // Stage 7: sixth power and the partial polynomial sum.
        n_s7_r6  = rldm_pkg::sat_u32(r_s6_r4r2 >> rldm_pkg::NORM_FRAC);
        n_s7_t2f = r_s6_t2p >>> rldm_pkg::NORM_FRAC;
        n_s7_t12 = r_s6_t1 + $signed(n_s7_t2f[36:0]);
        n_ovf[7] = n_s7_r6.ovf;

        // Stage 8: the k3 product.
        n_s8_t3p = r_k3 * $signed({1'b0, r_s7_r6});

        // Stage 9: radial scale factor.
        n_s9_t3f = r_s8_t3p >>> rldm_pkg::NORM_FRAC;
        n_s9_sum = rldm_pkg::ONE_Q28 + r_s8_t12 + $signed(n_s9_t3f[36:0]);
        n_s9_s   = rldm_pkg::sat_s32(n_s9_sum);
        n_ovf[9] = n_s9_s.ovf;

        // Stage 10: scale the normalized coordinates.
        n_s10_px = r_nx[9] * r_s9_s;
        n_s10_py = r_ny[9] * r_s9_s;

        // Stage 11: distorted normalized coordinates.
        n_s11_dx  = rldm_pkg::sat_s32(r_s10_px >>> rldm_pkg::NORM_FRAC);
        n_s11_dy  = rldm_pkg::sat_s32(r_s10_py >>> rldm_pkg::NORM_FRAC);
        n_ovf[11] = n_s11_dx.ovf || n_s11_dy.ovf;

        // Stage 12: back to pixels through the focal length.
        n_s12_px = r_s11_dx * $signed({1'b0, r_focal});
        n_s12_py = r_s11_dy * $signed({1'b0, r_focal});

        // Stage 13: round to the coordinate format, halves toward plus infinity.
        n_s13_shx = r_s12_px >>> BackShift;
        n_s13_shy = r_s12_py >>> BackShift;
        n_s13_hx  = (n_s13_shx + 65'sd1) >>> 1;
        n_s13_hy  = (n_s13_shy + 65'sd1) >>> 1;

        // Stage 14: add the principal point and clamp to the output range.
        n_s14_x   = rldm_pkg::sat_s20(r_s13_hx + $signed({49'd0, r_cx}));
        n_s14_y   = rldm_pkg::sat_s20(r_s13_hy + $signed({49'd0, r_cy}));
        n_ovf[14] = n_s14_x.ovf || n_s14_y.ovf;
    end

    // Stage data registers.
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_s0_px <= n_s0_px;
            r_s0_py <= n_s0_py;
        end
        if (stg_rdy[1]) begin
            r_nx[1]  <= n_s1_nx.val;
            r_ny[1]  <= n_s1_ny.val;
            r_flg[1] <= n_ovf[1];
        end
        for (int k = 2; k < NSTG; k++) begin
            if (stg_rdy[k]) begin
                r_flg[k] <= r_flg[k-1] || n_ovf[k];
            end
        end
        for (int k = 2; k <= 9; k++) begin
            if (stg_rdy[k]) begin
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
            end
        end
        if (stg_rdy[2]) begin
            r_s2_sqx <= n_s2_sqx;
            r_s2_sqy <= n_s2_sqy;
        end
        if (stg_rdy[3]) begin
            r_s3_r2 <= n_s3_r2.val;
        end
        if (stg_rdy[4]) begin
            r_s4_r2sq <= n_s4_r2sq;
            r_s4_t1p  <= n_s4_t1p;
            r_s4_r2   <= r_s3_r2;
        end
        if (stg_rdy[5]) begin
            r_s5_r4 <= n_s5_r4.val;
            r_s5_r2 <= r_s4_r2;
            r_s5_t1 <= n_s5_t1f[36:0];
        end
        if (stg_rdy[6]) begin
            r_s6_r4r2 <= n_s6_r4r2;
            r_s6_t2p  <= n_s6_t2p;
            r_s6_t1   <= r_s5_t1;
        end
        if (stg_rdy[7]) begin
            r_s7_r6  <= n_s7_r6.val;
            r_s7_t12 <= n_s7_t12;
        end
        if (stg_rdy[8]) begin
            r_s8_t3p <= n_s8_t3p;
            r_s8_t12 <= r_s7_t12;
        end
        if (stg_rdy[9]) begin
            r_s9_s <= n_s9_s.val;
        end
        if (stg_rdy[10]) begin
            r_s10_px <= n_s10_px;
            r_s10_py <= n_s10_py;
        end
        if (stg_rdy[11]) begin
            r_s11_dx <= n_s11_dx.val;
            r_s11_dy <= n_s11_dy.val;
        end
        if (stg_rdy[12]) begin
            r_s12_px <= n_s12_px;
            r_s12_py <= n_s12_py;
        end
        if (stg_rdy[13]) begin
            r_s13_hx <= n_s13_hx;
            r_s13_hy <= n_s13_hy;
        end
        if (stg_rdy[14]) begin
            r_s14_x <= n_s14_x.val;
            r_s14_y <= n_s14_y.val;
        end
    end

    // Output transaction.
    assign o_m_tvalid   = r_vld[NSTG-1];
    assign o_m_tdata    = {r_s14_y, r_s14_x};
    assign o_m_tuser[0] = r_flg[NSTG-1];

endmodule
